[rtl/core/bilrsz_pkg.sv]
`default_nettype none
package bilrsz_pkg;

  // Default sizes of the design
  localparam int MAX_SOURCE_WIDTH_DEF  = 512;
  localparam int MAX_SOURCE_HEIGHT_DEF = 512;
  localparam int MAX_DEST_SIZE_DEF     = 2048;
  localparam int FRACTION_BITS_DEF     = 10;

  // Field widths
  localparam int SIZE_W      = 10;
  localparam int STEP_W      = 16;
  localparam int COORD_W     = 11;
  localparam int PIXEL_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register values after reset
  localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RST    = 10'd512;
  localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RST   = 10'd512;
  localparam logic [STEP_W-1:0] HORIZONTAL_STEP_RST = 16'd1024;
  localparam logic [STEP_W-1:0] VERTICAL_STEP_RST   = 16'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SOURCE_WIDTH    = 2'd0,
    CFG_SOURCE_HEIGHT   = 2'd1,
    CFG_HORIZONTAL_STEP = 2'd2,
    CFG_VERTICAL_STEP   = 2'd3
  } cfg_index_t;

  typedef enum logic {
    FUNC_WRITE   = 1'b0,
    FUNC_COMPUTE = 1'b1
  } func_t;

endpackage
`default_nettype wire

[rtl/core/bilinear_resize_q10_gray_core.sv]
`default_nettype none
// Grayscale bilinear resizer. A write item (func 0) stores pixel_in at source
// column/row; a compute item (func 1) returns one interpolated destination
// pixel. The block takes one item per clock and holds that rate as long as
// out_stall stays low; a compute result leaves from the output register.
// The frame store is split into four RAM banks by column and row parity, so
// the four neighbors of a compute item are read in the same cycle, one read
// per bank. Writes and reads both go to the banks from the same pipeline
// stage in arrival order, so a compute item always sees every write accepted
// before it. The store has no reset and needs no clearing pass; reading a
// pixel that was never written gives an undefined value. Configuration writes
// are always taken (cfg_ready is high) and must only happen while idle.
module bilinear_resize_q10_gray_core #(
  parameter int MAX_SOURCE_WIDTH  = bilrsz_pkg::MAX_SOURCE_WIDTH_DEF,
  parameter int MAX_SOURCE_HEIGHT = bilrsz_pkg::MAX_SOURCE_HEIGHT_DEF,
  parameter int MAX_DEST_SIZE     = bilrsz_pkg::MAX_DEST_SIZE_DEF,
  parameter int FRACTION_BITS     = bilrsz_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                func,
  input  wire logic [bilrsz_pkg::COORD_W-1:0]      column,
  input  wire logic [bilrsz_pkg::COORD_W-1:0]      row,
  input  wire logic [bilrsz_pkg::PIXEL_W-1:0]      pixel_in,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [bilrsz_pkg::PIXEL_W-1:0]      pixel_out,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [bilrsz_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bilrsz_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int XW     = (MAX_SOURCE_WIDTH > 2) ? $clog2(MAX_SOURCE_WIDTH) : 1;
  localparam int YW     = (MAX_SOURCE_HEIGHT > 2) ? $clog2(MAX_SOURCE_HEIGHT) : 1;
  localparam int DW     = $clog2(MAX_DEST_SIZE);
  localparam int SW     = bilrsz_pkg::STEP_W;
  localparam int PW     = DW + SW;
  localparam int PXW    = bilrsz_pkg::PIXEL_W;
  localparam int CW     = bilrsz_pkg::COORD_W;
  localparam int HALF_W = (MAX_SOURCE_WIDTH + 1) / 2;
  localparam int HALF_H = (MAX_SOURCE_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // a + floor((b - a) * f / 2^F)
  function automatic logic [PXW-1:0] lerp(input logic [PXW-1:0] a, input logic [PXW-1:0] b,
                                          input logic [FRACTION_BITS-1:0] f);
    logic signed [PXW:0]               d;
    logic signed [PXW+FRACTION_BITS+1:0] prod;
    logic signed [PXW+FRACTION_BITS+1:0] q;
    d    = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = d * $signed({1'b0, f});
    q    = prod >>> FRACTION_BITS;
    return a + q[PXW-1:0];
  endfunction

  // configuration registers
  logic [bilrsz_pkg::SIZE_W-1:0] source_width;
  logic [bilrsz_pkg::SIZE_W-1:0] source_height;
  logic [SW-1:0]                 horizontal_step;
  logic [SW-1:0]                 vertical_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width    <= bilrsz_pkg::SOURCE_WIDTH_RST;
      source_height   <= bilrsz_pkg::SOURCE_HEIGHT_RST;
      horizontal_step <= bilrsz_pkg::HORIZONTAL_STEP_RST;
      vertical_step   <= bilrsz_pkg::VERTICAL_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bilrsz_pkg::cfg_index_t'(cfg_index))
        bilrsz_pkg::CFG_SOURCE_WIDTH:    source_width    <= cfg_data[bilrsz_pkg::SIZE_W-1:0];
        bilrsz_pkg::CFG_SOURCE_HEIGHT:   source_height   <= cfg_data[bilrsz_pkg::SIZE_W-1:0];
        bilrsz_pkg::CFG_HORIZONTAL_STEP: horizontal_step <= cfg_data[SW-1:0];
        bilrsz_pkg::CFG_VERTICAL_STEP:   vertical_step   <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valids
  logic v1, v2, v3, v4, v5, v6;
  logic leave1, leave2, leave3, leave4, leave5, leave6;
  logic free1, free2, free3, free4, free5, free6;
  logic accept, wr3, rd_issue, wr_fire;

  // stage payloads
  logic                     f1, f2, f3;
  logic [CW-1:0]            c1, r1, c2, r2;
  logic [PXW-1:0]           p1, p2, p3;
  logic [PW-1:0]            pos_x2, pos_y2;
  logic [XW-1:0]            x0_3, x1_3;
  logic [YW-1:0]            y0_3, y1_3;
  logic [FRACTION_BITS-1:0] fx3, fy3, fx4, fy4, fy5;
  logic                     wok3;
  logic                     x0b4, x1b4, y0b4, y1b4;
  logic [PXW-1:0]           top5, bot5;

  logic [DW-1:0]            col_sat, row_sat;
  logic [PW-1:0]            pos_x_next, pos_y_next;
  logic [XW-1:0]            ax_i0, ax_i1;
  logic [YW-1:0]            ay_i0, ay_i1;
  logic [FRACTION_BITS-1:0] ax_frac, ay_frac;
  logic                     wok_next;
  logic [3:0][PXW-1:0]      bank_q;
  logic [PXW-1:0]           p00, p10, p01, p11;
  logic [1:0]               wr_bank;
  logic [AW-1:0]            wr_addr;

  // a stage frees up when empty or when its item moves on
  always_comb begin
    free6  = !v6 || !out_stall;
    leave6 = v6 && !out_stall;
    leave5 = v5 && free6;
    free5  = !v5 || free6;
    leave4 = v4 && free5;
    free4  = !v4 || free5;
    wr3    = v3 && (f3 == bilrsz_pkg::FUNC_WRITE);
    leave3 = wr3 || (v3 && free4);
    free3  = !v3 || leave3;
    leave2 = v2 && free3;
    free2  = !v2 || free3;
    leave1 = v1 && free2;
    free1  = !v1 || free2;
    accept = in_valid && free1;
    rd_issue = leave3 && !wr3;
    wr_fire  = wr3 && wok3;
  end

  assign in_stall  = !free1;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= accept   || (v1 && !leave1);
      v2 <= leave1   || (v2 && !leave2);
      v3 <= leave2   || (v3 && !leave3);
      v4 <= rd_issue || (v4 && !leave4);
      v5 <= leave4   || (v5 && !leave5);
      v6 <= leave5   || (v6 && !leave6);
    end
  end

  // stage 1: register the item
  always_ff @(posedge clk) begin
    if (accept) begin
      f1 <= func;
      c1 <= column;
      r1 <= row;
      p1 <= pixel_in;
    end
  end

  // stage 2: source position = destination coordinate * step
  always_comb begin
    col_sat = DW'((32'(c1) >= 32'(MAX_DEST_SIZE)) ? 32'(MAX_DEST_SIZE - 1) : 32'(c1));
    row_sat = DW'((32'(r1) >= 32'(MAX_DEST_SIZE)) ? 32'(MAX_DEST_SIZE - 1) : 32'(r1));
    pos_x_next = {{SW{1'b0}}, col_sat} * {{DW{1'b0}}, horizontal_step};
    pos_y_next = {{SW{1'b0}}, row_sat} * {{DW{1'b0}}, vertical_step};
  end

  always_ff @(posedge clk) begin
    if (leave1) begin
      f2     <= f1;
      c2     <= c1;
      r2     <= r1;
      p2     <= p1;
      pos_x2 <= pos_x_next;
      pos_y2 <= pos_y_next;
    end
  end

  // stage 3: neighbor indices and fractions
  bilrsz_axis #(
    .MAX_SIZE      (MAX_SOURCE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .POS_W         (PW)
  ) u_axis_x (
    .pos  (pos_x2),
    .size (source_width),
    .i0   (ax_i0),
    .i1   (ax_i1),
    .frac (ax_frac)
  );

  bilrsz_axis #(
    .MAX_SIZE      (MAX_SOURCE_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS),
    .POS_W         (PW)
  ) u_axis_y (
    .pos  (pos_y2),
    .size (source_height),
    .i0   (ay_i0),
    .i1   (ay_i1),
    .frac (ay_frac)
  );

  assign wok_next = (32'(c2) < 32'(MAX_SOURCE_WIDTH)) && (32'(r2) < 32'(MAX_SOURCE_HEIGHT));

  always_ff @(posedge clk) begin
    if (leave2) begin
      f3   <= f2;
      p3   <= p2;
      wok3 <= wok_next;
      fx3  <= ax_frac;
      fy3  <= ay_frac;
      // write items carry their source coordinate in the x0/y0 slots
      if (f2 == bilrsz_pkg::FUNC_COMPUTE) begin
        x0_3 <= ax_i0;
        x1_3 <= ax_i1;
        y0_3 <= ay_i0;
        y1_3 <= ay_i1;
      end else begin
        x0_3 <= XW'(c2);
        x1_3 <= XW'(c2);
        y0_3 <= YW'(r2);
        y1_3 <= YW'(r2);
      end
    end
  end

  // frame store: four banks by (row parity, column parity)
  assign wr_bank = {y0_3[0], x0_3[0]};
  assign wr_addr = AW'((32'(y0_3) >> 1) * 32'(HALF_W) + (32'(x0_3) >> 1));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW-1:0] xs;
    logic [YW-1:0] ys;
    logic [AW-1:0] rd_addr;

    // pick whichever neighbor index has this bank's parity
    always_comb begin
      xs = (x0_3[0] == b[0]) ? x0_3 : x1_3;
      ys = (y0_3[0] == b[1]) ? y0_3 : y1_3;
      rd_addr = AW'((32'(ys) >> 1) * 32'(HALF_W) + (32'(xs) >> 1));
    end

    bilrsz_ram #(
      .WIDTH (PXW),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_fire && (wr_bank == 2'(b))),
      .waddr (wr_addr),
      .wdata (p3),
      .re    (rd_issue),
      .raddr (rd_addr),
      .rdata (bank_q[b])
    );
  end

  // stage 4: bank data arrives
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      fx4  <= fx3;
      fy4  <= fy3;
      x0b4 <= x0_3[0];
      x1b4 <= x1_3[0];
      y0b4 <= y0_3[0];
      y1b4 <= y1_3[0];
    end
  end

  always_comb begin
    p00 = bank_q[{y0b4, x0b4}];
    p10 = bank_q[{y0b4, x1b4}];
    p01 = bank_q[{y1b4, x0b4}];
    p11 = bank_q[{y1b4, x1b4}];
  end

  // stage 5: horizontal blend on both rows
  always_ff @(posedge clk) begin
    if (leave4) begin
      top5 <= lerp(p00, p10, fx4);
      bot5 <= lerp(p01, p11, fx4);
      fy5  <= fy4;
    end
  end

  // stage 6: vertical blend into the output register
  always_ff @(posedge clk) begin
    if (leave5) begin
      pixel_out <= lerp(top5, bot5, fy5);
    end
  end

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted item did not enter stage 1");

  a_neighbor_order: assert property (@(posedge clk) disable iff (rst)
    v3 && (f3 == bilrsz_pkg::FUNC_COMPUTE) |->
      (x1_3 == x0_3 || x1_3 == x0_3 + XW'(1)) && (y1_3 == y0_3 || y1_3 == y0_3 + YW'(1)))
    else $error("neighbor index pair out of order");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    rd_issue |=> v4)
    else $error("bank read issued without a stage 4 item");

  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !free5 |=> v4 && $stable(p00) && $stable(p10) && $stable(p01) && $stable(p11)
      && $stable(fx4))
    else $error("stalled stage 4 lost its bank data");

endmodule
`default_nettype wire

[rtl/core/bilrsz_ram.sv]
`default_nettype none
module bilrsz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/bilrsz_axis.sv]
`default_nettype none
module bilrsz_axis #(
  parameter int MAX_SIZE      = 512,
  parameter int FRACTION_BITS = 10,
  parameter int POS_W         = 27,
  localparam int IW = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1
) (
  input  wire logic [POS_W-1:0]              pos,
  input  wire logic [bilrsz_pkg::SIZE_W-1:0] size,
  output logic      [IW-1:0]                 i0,
  output logic      [IW-1:0]                 i1,
  output logic      [FRACTION_BITS-1:0]      frac
);

  logic [31:0]   size_ext;
  logic [31:0]   size_clamped;
  logic [IW-1:0] last;
  logic [31:0]   ip;
  logic [31:0]   ip_clamped;

  always_comb begin
    size_ext = 32'(size);
    if (size_ext < 32'd2) begin
      size_clamped = 32'd2;
    end else if (size_ext > 32'(MAX_SIZE)) begin
      size_clamped = 32'(MAX_SIZE);
    end else begin
      size_clamped = size_ext;
    end
    last = IW'(size_clamped - 32'd1);

    // integer part from the raw product, pinned to [1, size-1]
    ip = 32'(pos[POS_W-1:FRACTION_BITS]);
    if (ip < 32'd1) begin
      ip_clamped = 32'd1;
    end else if (ip > 32'(last)) begin
      ip_clamped = 32'(last);
    end else begin
      ip_clamped = ip;
    end
    i0 = IW'(ip_clamped);
    i1 = (i0 == last) ? last : i0 + IW'(1);
    frac = pos[FRACTION_BITS-1:0];
  end

endmodule
`default_nettype wire
